// File: hw/rtl/clp_pkg.sv
// Shared constants, operation codes and types of the cursor list engine.
`default_nettype none
package clp_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int FUNC_W = 4;

    typedef enum logic [FUNC_W-1:0] {
        OP_CLEAR    = 4'd0,
        OP_INSERT   = 4'd1,
        OP_REMOVE   = 4'd2,
        OP_VFWD     = 4'd3,
        OP_VBWD     = 4'd4,
        OP_CFWD     = 4'd5,
        OP_CBWD     = 4'd6,
        OP_READ     = 4'd7,
        OP_WRITE    = 4'd8,
        OP_CONTAINS = 4'd9
    } op_t;

    // What the shared walk does with each word it fetches
    typedef enum logic [1:0] {
        WM_INS   = 2'd0,
        WM_REM   = 2'd1,
        WM_SCAN  = 2'd2,
        WM_FETCH = 2'd3
    } walk_mode_t;

endpackage
`default_nettype wire

// File: hw/rtl/clp_req_if.sv
// Request channel: operation selector and value word.
`default_nettype none
interface clp_req_if
    import clp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/clp_rsp_if.sv
// Response channel: read word, flags, list length and cursor.
`default_nettype none
interface clp_rsp_if
    import clp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_value;
    logic              found;
    logic              applied;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] cursor;

    modport source (output valid, output read_value, output found, output applied,
                    output length, output cursor, input ready);
    modport sink   (input valid, input read_value, input found, input applied,
                    input length, input cursor, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cursor_list_engine.sv
// Top level of the cursor list engine: sequencer, entry memory and response register.
//
// A bounded ordered list of up to DEPTH (64) 32-bit words with a cursor, held in a
// single-port-write, single-port-read memory with registered read data. One request
// word is taken at a time; the request port is ready only while the sequencer is idle.
// Every request gives exactly one response word. Clear, cursor moves and refused
// operations go straight to the response state; write, read and the neighbour swaps
// pass through their own memory states first. Insert, remove and contains walk the
// list through the one memory read port, one entry per cycle; insert and remove walk
// only the entries they move, contains every live entry, and insert then puts the
// new word in its slot. The response sits in an output register, so the next request
// is taken while a response still waits for its sink. Entries beyond the current
// length are never read; the memory needs no clearing after reset.
`default_nettype none
module cursor_list_engine
    import clp_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    clp_req_if.sink      req,
    clp_rsp_if.source    rsp
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_WALK  = 9'b000000010,
        S_PUT   = 9'b000000100,
        S_WRITE = 9'b000001000,
        S_SWA   = 9'b000010000,
        S_SWB   = 9'b000100000,
        S_SWC   = 9'b001000000,
        S_SWD   = 9'b010000000,
        S_RESP  = 9'b100000000
    } state_t;

    // Entry memory
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;

    // Sequencer and list state
    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    walk_mode_t        mode_reg, mode_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] other_reg, other_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] tmp_reg, tmp_next;

    // Result under construction
    logic [DATA_W-1:0] rd_reg, rd_next;
    logic              found_reg, found_next;
    logic              applied_reg, applied_next;

    // Response register
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_rd_reg, out_rd_next;
    logic              out_found_reg, out_found_next;
    logic              out_applied_reg, out_applied_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic [ADDR_W-1:0] out_cur_reg, out_cur_next;

    logic              accept;
    logic              load_out;
    logic [LEN_W-1:0]  cur_ext;
    logic [LEN_W-1:0]  cur_inc;
    logic              cur_in_list;
    logic [LEN_W-1:0]  ins_pos;

    assign req.ready   = (state_reg == S_IDLE);
    assign accept      = req.valid && req.ready;
    assign cur_ext     = {1'b0, cur_reg};
    assign cur_inc     = cur_ext + LEN_W'(1);
    assign cur_in_list = cur_ext < len_reg;

    // Insert slot: slot 0 on an empty list, else after the cursor, clamped to the end
    always_comb
    begin
        if (len_reg == '0)
            ins_pos = '0;
        else if (cur_inc > len_reg)
            ins_pos = len_reg;
        else
            ins_pos = cur_inc;
    end

    assign load_out = (state_reg == S_RESP) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        cur_next       = cur_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        addr_next      = addr_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pos_next       = pos_reg;
        other_next     = other_reg;
        val_next       = val_reg;
        tmp_next       = tmp_reg;
        rd_next        = rd_reg;
        found_next     = found_reg;
        applied_next   = applied_reg;
        we             = 1'b0;
        waddr          = pend_addr_reg;
        wdata          = rdata_reg;
        raddr          = addr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next     = req.value;
                    rd_next      = '0;
                    found_next   = 1'b0;
                    applied_next = 1'b0;
                    state_next   = S_RESP;
                    case (op_t'(req.func))
                        OP_CLEAR:
                        begin
                            len_next     = '0;
                            cur_next     = '0;
                            applied_next = 1'b1;
                        end
                        OP_INSERT:
                        begin
                            if (len_reg < LEN_W'(DEPTH))
                            begin
                                // shift len-1 .. pos up by one, top first
                                mode_next    = WM_INS;
                                pos_next     = ins_pos[ADDR_W-1:0];
                                cnt_next     = len_reg - ins_pos;
                                addr_next    = len_reg[ADDR_W-1:0] - ADDR_W'(1);
                                len_next     = len_reg + LEN_W'(1);
                                applied_next = 1'b1;
                                state_next   = S_WALK;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (cur_in_list)
                            begin
                                // shift cur+1 .. len-1 down by one
                                mode_next    = WM_REM;
                                cnt_next     = len_reg - cur_inc;
                                addr_next    = cur_reg + ADDR_W'(1);
                                len_next     = len_reg - LEN_W'(1);
                                applied_next = 1'b1;
                                state_next   = S_WALK;
                            end
                        end
                        OP_VFWD:
                        begin
                            if (cur_inc < len_reg)
                            begin
                                other_next   = cur_reg + ADDR_W'(1);
                                applied_next = 1'b1;
                                state_next   = S_SWA;
                            end
                        end
                        OP_VBWD:
                        begin
                            if (cur_reg != '0 && cur_in_list)
                            begin
                                other_next   = cur_reg - ADDR_W'(1);
                                applied_next = 1'b1;
                                state_next   = S_SWA;
                            end
                        end
                        OP_CFWD:
                        begin
                            if (cur_inc < len_reg)
                            begin
                                cur_next     = cur_reg + ADDR_W'(1);
                                applied_next = 1'b1;
                            end
                        end
                        OP_CBWD:
                        begin
                            if (cur_reg != '0)
                            begin
                                cur_next     = cur_reg - ADDR_W'(1);
                                applied_next = 1'b1;
                            end
                        end
                        OP_READ:
                        begin
                            if (cur_in_list)
                            begin
                                mode_next    = WM_FETCH;
                                cnt_next     = LEN_W'(1);
                                addr_next    = cur_reg;
                                applied_next = 1'b1;
                                state_next   = S_WALK;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (cur_in_list)
                            begin
                                applied_next = 1'b1;
                                state_next   = S_WRITE;
                            end
                        end
                        OP_CONTAINS:
                        begin
                            mode_next    = WM_SCAN;
                            cnt_next     = len_reg;
                            addr_next    = '0;
                            applied_next = 1'b1;
                            state_next   = S_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // issue one read a cycle while words remain
                if (cnt_reg != '0)
                begin
                    raddr     = addr_reg;
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg - LEN_W'(1);
                    if (mode_reg == WM_INS)
                    begin
                        pend_addr_next = addr_reg + ADDR_W'(1);
                        addr_next      = addr_reg - ADDR_W'(1);
                    end
                    else
                    begin
                        pend_addr_next = addr_reg - ADDR_W'(1);
                        addr_next      = addr_reg + ADDR_W'(1);
                    end
                end
                // retire the word fetched last cycle
                if (pend_reg)
                begin
                    case (mode_reg)
                        WM_INS, WM_REM:
                            we = 1'b1;
                        WM_SCAN:
                            if (rdata_reg == val_reg)
                                found_next = 1'b1;
                        WM_FETCH:
                            rd_next = rdata_reg;
                        default:
                        begin
                        end
                    endcase
                end
                if (cnt_reg == '0 && !pend_reg)
                    state_next = (mode_reg == WM_INS) ? S_PUT : S_RESP;
            end

            S_PUT:
            begin
                we         = 1'b1;
                waddr      = pos_reg;
                wdata      = val_reg;
                state_next = S_RESP;
            end

            S_WRITE:
            begin
                we         = 1'b1;
                waddr      = cur_reg;
                wdata      = val_reg;
                state_next = S_RESP;
            end

            S_SWA:
            begin
                raddr      = cur_reg;
                state_next = S_SWB;
            end

            S_SWB:
            begin
                raddr      = other_reg;
                tmp_next   = rdata_reg;
                state_next = S_SWC;
            end

            S_SWC:
            begin
                we         = 1'b1;
                waddr      = cur_reg;
                wdata      = rdata_reg;
                state_next = S_SWD;
            end

            S_SWD:
            begin
                we         = 1'b1;
                waddr      = other_reg;
                wdata      = tmp_reg;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Response register: drop on take, load when the sequencer finishes
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_rd_next      = out_rd_reg;
        out_found_next   = out_found_reg;
        out_applied_next = out_applied_reg;
        out_len_next     = out_len_reg;
        out_cur_next     = out_cur_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        if (load_out)
        begin
            out_valid_next   = 1'b1;
            out_rd_next      = rd_reg;
            out_found_next   = found_reg;
            out_applied_next = applied_reg;
            out_len_next     = len_reg;
            out_cur_next     = cur_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_rd_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.applied    = out_applied_reg;
    assign rsp.length     = out_len_reg;
    assign rsp.cursor     = out_cur_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            cur_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cur_reg       <= cur_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        cnt_reg         <= cnt_next;
        addr_reg        <= addr_next;
        pend_addr_reg   <= pend_addr_next;
        pos_reg         <= pos_next;
        other_reg       <= other_next;
        val_reg         <= val_next;
        tmp_reg         <= tmp_next;
        rd_reg          <= rd_next;
        found_reg       <= found_next;
        applied_reg     <= applied_next;
        out_rd_reg      <= out_rd_next;
        out_found_reg   <= out_found_next;
        out_applied_reg <= out_applied_next;
        out_len_reg     <= out_len_next;
        out_cur_reg     <= out_cur_next;
    end

endmodule
`default_nettype wire

// File: verif/cursor_list_engine_tb.sv
`timescale 1ns / 1ps
// Testbench for the cursor list engine: directed and random list operations checked against a shadow list.
module cursor_list_engine_tb;
    import clp_pkg::*;

    // One expected response word, tagged with the operation that caused it
    typedef struct {
        logic [FUNC_W-1:0] op;
        logic [DATA_W-1:0] read_value;
        logic              found;
        logic              applied;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] cursor;
    } list_result_t;

    logic clk;
    logic rst_n;

    clp_req_if req_bus ();
    clp_rsp_if rsp_bus ();

    cursor_list_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Shadow copy of the list: entries, length and cursor as the engine should hold them
    logic [DATA_W-1:0] shadow_words [DEPTH];
    int                shadow_len;
    int                shadow_cur;

    list_result_t      expected_results [$];
    int                mismatches     = 0;
    int                words_sent     = 0;
    int                src_idle_pct   = 10;
    int                sink_stall_pct = 83;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop: far beyond the slowest correct run (every walk on a full list, long stalls)
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow list: apply one operation and return the response it gives.
    // The cursor may sit one past the last entry after removing the tail;
    // an insert from there appends, and cursor-bound ops are refused.
    // ------------------------------------------------------------------
    function automatic list_result_t apply_list_op(logic [FUNC_W-1:0] op,
                                                   logic [DATA_W-1:0] word);
        list_result_t      res;
        logic [DATA_W-1:0] held;
        int                pos;
        int                k;
        bit                in_list;

        res            = '{default: '0};
        res.op         = op;
        in_list        = shadow_cur < shadow_len;

        case (op)
            OP_CLEAR:
            begin
                shadow_len  = 0;
                shadow_cur  = 0;
                res.applied = 1'b1;
            end
            OP_INSERT:
            begin
                if (shadow_len < DEPTH)
                begin
                    // empty list takes slot 0; otherwise after the cursor, clamped to the end
                    pos = (shadow_len == 0) ? 0 : shadow_cur + 1;
                    if (pos > shadow_len)
                        pos = shadow_len;
                    for (k = shadow_len; k > pos; k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[pos] = word;
                    shadow_len++;
                    res.applied = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (in_list)
                begin
                    // close the gap; the cursor stays put even if it falls off the end
                    for (k = shadow_cur; k + 1 < shadow_len; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_len--;
                    res.applied = 1'b1;
                end
            end
            OP_VFWD:
            begin
                if (shadow_cur + 1 < shadow_len)
                begin
                    held                       = shadow_words[shadow_cur];
                    shadow_words[shadow_cur]   = shadow_words[shadow_cur+1];
                    shadow_words[shadow_cur+1] = held;
                    res.applied                = 1'b1;
                end
            end
            OP_VBWD:
            begin
                if (shadow_cur != 0 && in_list)
                begin
                    held                       = shadow_words[shadow_cur];
                    shadow_words[shadow_cur]   = shadow_words[shadow_cur-1];
                    shadow_words[shadow_cur-1] = held;
                    res.applied                = 1'b1;
                end
            end
            OP_CFWD:
            begin
                if (shadow_cur + 1 < shadow_len)
                begin
                    shadow_cur++;
                    res.applied = 1'b1;
                end
            end
            OP_CBWD:
            begin
                if (shadow_cur != 0)
                begin
                    shadow_cur--;
                    res.applied = 1'b1;
                end
            end
            OP_READ:
            begin
                if (in_list)
                begin
                    res.read_value = shadow_words[shadow_cur];
                    res.applied    = 1'b1;
                end
            end
            OP_WRITE:
            begin
                if (in_list)
                begin
                    shadow_words[shadow_cur] = word;
                    res.applied              = 1'b1;
                end
            end
            OP_CONTAINS:
            begin
                // search only the live part of the list
                for (k = 0; k < shadow_len; k++)
                    if (shadow_words[k] == word)
                        res.found = 1'b1;
                res.applied = 1'b1;
            end
            default:
            begin
                // unused selector: nothing changes, not applied
            end
        endcase

        res.length = shadow_len[LEN_W-1:0];
        res.cursor = shadow_cur[ADDR_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side: present one word, hold it until taken, then predict.
    // Valid stays high on return so back-to-back words go out without a gap.
    // ------------------------------------------------------------------
    task automatic send_word(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] word);
        int gap;

        gap = 0;
        while ($urandom_range(0, 99) < src_idle_pct)
            gap++;
        if (gap != 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end

        req_bus.valid <= 1'b1;
        req_bus.func  <= op;
        req_bus.value <= word;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);

        expected_results.push_back(apply_list_op(op, word));
        words_sent++;
    endtask

    task automatic note_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Response side: check each accepted word against the oldest
    // prediction, then choose the next ready at random.
    // ------------------------------------------------------------------
    task automatic check_list_result();
        list_result_t want;

        if (expected_results.size() == 0)
        begin
            note_failure($sformatf("response with nothing expected: rd=%h len=%0d cur=%0d",
                                   rsp_bus.read_value, rsp_bus.length, rsp_bus.cursor));
            return;
        end
        want = expected_results.pop_front();
        if (rsp_bus.read_value !== want.read_value || rsp_bus.found !== want.found ||
            rsp_bus.applied !== want.applied || rsp_bus.length !== want.length ||
            rsp_bus.cursor !== want.cursor)
            note_failure($sformatf({"op %0d mismatch: expected rd=%h found=%b applied=%b ",
                                    "len=%0d cur=%0d, got rd=%h found=%b applied=%b ",
                                    "len=%0d cur=%0d"},
                                   want.op, want.read_value, want.found, want.applied,
                                   want.length, want.cursor, rsp_bus.read_value,
                                   rsp_bus.found, rsp_bus.applied, rsp_bus.length,
                                   rsp_bus.cursor));
    endtask

    initial
    begin
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
                check_list_result();
            rsp_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Word to store: weight the extremes and a small range so duplicates occur
    function automatic logic [DATA_W-1:0] pick_word();
        int roll;

        roll = $urandom_range(0, 99);
        if (roll < 12)
            return '0;
        if (roll < 24)
            return '1;
        if (roll < 45)
            return $urandom_range(0, 7);
        return $urandom;
    endfunction

    // Search key: often a live entry, sometimes a stale one past the end
    function automatic logic [DATA_W-1:0] pick_probe();
        int roll;

        roll = $urandom_range(0, 99);
        if (roll < 50 && shadow_len > 0)
            return shadow_words[$urandom_range(0, shadow_len - 1)];
        if (roll < 65 && shadow_len > 0 && shadow_len < DEPTH)
            return shadow_words[$urandom_range(shadow_len, DEPTH - 1)];
        return pick_word();
    endfunction

    function automatic logic [FUNC_W-1:0] pick_list_op();
        int roll;

        roll = $urandom_range(0, 99);
        if (roll < 2)
            return OP_CLEAR;
        if (roll < 6)
            return FUNC_W'($urandom_range(10, 15));
        if (roll < 20)
            return OP_INSERT;
        if (roll < 31)
            return OP_REMOVE;
        if (roll < 39)
            return OP_VFWD;
        if (roll < 47)
            return OP_VBWD;
        if (roll < 59)
            return OP_CFWD;
        if (roll < 69)
            return OP_CBWD;
        if (roll < 80)
            return OP_READ;
        if (roll < 89)
            return OP_WRITE;
        return OP_CONTAINS;
    endfunction

    task automatic send_random_op();
        logic [FUNC_W-1:0] op;

        op = pick_list_op();
        send_word(op, (op == OP_CONTAINS) ? pick_probe() : pick_word());
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Every cursor-bound op and an unused selector refused on an empty list; search finds nothing
    task automatic test_empty_list();
        send_word(OP_REMOVE,   32'h0);
        send_word(OP_VFWD,     32'h0);
        send_word(OP_VBWD,     32'h0);
        send_word(OP_CFWD,     32'h0);
        send_word(OP_CBWD,     32'h0);
        send_word(OP_READ,     32'h0);
        send_word(OP_WRITE,    32'hFFFF_FFFF);
        send_word(OP_CONTAINS, 32'h0);
        send_word(4'hF,        32'hFFFF_FFFF);
    endtask

    // Build a short list, walk it, swap, overwrite and search
    task automatic test_insert_and_walk();
        send_word(OP_INSERT,   32'h0000_0000);
        send_word(OP_INSERT,   32'hFFFF_FFFF);
        send_word(OP_INSERT,   32'h1234_5678);
        send_word(OP_READ,     32'h0);
        send_word(OP_CFWD,     32'h0);
        send_word(OP_CFWD,     32'h0);
        send_word(OP_CFWD,     32'h0);
        send_word(OP_VFWD,     32'h0);
        send_word(OP_VBWD,     32'h0);
        send_word(OP_CONTAINS, 32'hFFFF_FFFF);
        send_word(OP_WRITE,    32'h8000_0001);
        send_word(OP_CBWD,     32'h0);
        send_word(OP_READ,     32'h0);
    endtask

    // Remove the tail so the cursor falls off the end, then append from there
    task automatic test_cursor_past_end();
        send_word(OP_CFWD,   32'h0);
        send_word(OP_REMOVE, 32'h0);
        send_word(OP_READ,   32'h0);
        send_word(OP_REMOVE, 32'h0);
        send_word(OP_INSERT, 32'hA5A5_A5A5);
        send_word(OP_CLEAR,  32'hFFFF_FFFF);
    endtask

    // ------------------------------------------------------------------
    // Random test: episodes of clear (most of them), fill (sometimes past full), cursor
    // sweep towards the tail, then a mix of every operation.
    // ------------------------------------------------------------------
    task automatic test_random_lists(int src_pct, int sink_pct, int quota);
        int stop_at;
        int fill;
        int sweep;
        int mix;
        int k;

        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        stop_at        = words_sent + quota;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 3) != 0)
                send_word(OP_CLEAR, $urandom);

            // a quarter of the episodes send a long fill that can run the list up to full and beyond
            fill = ($urandom_range(0, 3) == 0) ? $urandom_range(56, 70) : $urandom_range(1, 12);
            for (k = 0; k < fill; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_word($urandom_range(0, 1) ? OP_CFWD : OP_CBWD, pick_word());
                else
                    send_word(OP_INSERT, pick_word());
            end

            // drive the cursor towards (and into) the tail
            sweep = $urandom_range(0, shadow_len + 2);
            for (k = 0; k < sweep; k++)
                send_word(OP_CFWD, pick_word());

            mix = $urandom_range(5, 30);
            for (k = 0; k < mix; k++)
                send_random_op();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.func  <= OP_CLEAR;
        req_bus.value <= '0;
        shadow_words  = '{default: '0};
        shadow_len    = 0;
        shadow_cur    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_insert_and_walk();
        test_cursor_past_end();
        test_random_lists(10, 83, 250);
        test_random_lists(83, 10, 250);
        test_random_lists(0, 0, 250);

        // drop valid, drain, then give a full-list walk's worth of cycles for strays
        req_bus.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
